// ----- rtl/core/itar_pkg.sv -----
// ----------------------------------------------------------------------------
// itar_pkg
// Shared widths, codes, types and helpers for the integer-to-ASCII converter.
// ----------------------------------------------------------------------------
package itar_pkg;

  localparam int VALUE_W       = 32;
  localparam int KIND_W        = 2;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int NUM_CELLS     = 10;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(STEPS);
  localparam int IDX_W         = $clog2(NUM_CELLS);

  typedef enum logic [KIND_W-1:0] {
    KIND_SDEC = 2'd0,
    KIND_UDEC = 2'd1,
    KIND_HEX  = 2'd2
  } kind_t;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [NUM_CELLS-1:0] digit_row_t;

  // control common to every cell of the row
  typedef struct packed {
    logic clear;   // load zero
    logic shift;   // take BITS_PER_STEP bits from the lower neighbor
    logic dabble;  // BCD add-3 correction (off for hex)
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input digit_t d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LA + CHAR_W'(d - DIGIT_W'(10));
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/itar_cell.sv -----
// ----------------------------------------------------------------------------
// itar_cell
// One 4-bit digit cell: shift-and-add-3 over several bits per clock while shift is set (add-3 only with dabble).
// ----------------------------------------------------------------------------
module itar_cell (
  input  logic                              clk,
  input  itar_pkg::cell_ctl_t               ctl,
  input  logic [itar_pkg::BITS_PER_STEP-1:0] cin,   // bit j enters at sub-step j
  output logic [itar_pkg::BITS_PER_STEP-1:0] cout,  // bit j leaves at sub-step j
  output itar_pkg::digit_t                  digit
);
  import itar_pkg::*;

  digit_t digit_next;

  always_comb begin
    digit_t v;
    digit_t a;
    v    = digit;
    cout = '0;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      a       = (ctl.dabble && v >= DIGIT_W'(5)) ? v + DIGIT_W'(3) : v;
      cout[j] = a[DIGIT_W-1];
      v       = {a[DIGIT_W-2:0], cin[j]};
    end
    digit_next = v;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.shift) begin
      digit <= digit_next;
    end
  end

endmodule

// ----- rtl/core/itar_digit_chain.sv -----
// ----------------------------------------------------------------------------
// itar_digit_chain
// Row of digit cells; each passes its carries to the next more significant one.
// ----------------------------------------------------------------------------
module itar_digit_chain (
  input  logic                               clk,
  input  itar_pkg::cell_ctl_t                ctl,
  input  logic [itar_pkg::BITS_PER_STEP-1:0] bits_in,  // bit j = j-th bit, MSB first
  output itar_pkg::digit_row_t               digits
);
  import itar_pkg::*;

  logic [BITS_PER_STEP-1:0] carry [NUM_CELLS+1];

  assign carry[0] = bits_in;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    itar_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .cin   (carry[i]),
      .cout  (carry[i+1]),
      .digit (digits[i])
    );
  end

  // top cell overflow is always zero for 32-bit operands
  logic unused_top;
  assign unused_top = ^carry[NUM_CELLS];

endmodule

// ----- rtl/core/int_to_ascii_radix.sv -----
// ----------------------------------------------------------------------------
// int_to_ascii_radix
// Converts a 32-bit value to ASCII text in signed/unsigned decimal or hex.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries the value, s_tuser the kind (0 signed decimal,
// 1 unsigned decimal, 2 lowercase hex, 3 treated as unsigned decimal).
// Output stream: one character per transaction, most significant first,
// m_tlast on the final character. A negative signed value is led by '-';
// no leading zeros, zero gives "0", no terminator.
// Timing: one number at a time. After the input transaction the value is
// shifted into a row of ten BCD cells, four bits per clock (cells shift
// plainly in hex mode); the load state then finds the leading digit and
// registers the first character. A number gives 1 to 11 characters.
// s_tready is high only while idle.
// Reset: returns to idle, drops m_tvalid, discards any number in progress.
// Stall: while m_tready is low the current character and m_tlast hold.
// ----------------------------------------------------------------------------
module int_to_ascii_radix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [itar_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
  input  logic [itar_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [itar_pkg::CHAR_W-1:0]    m_tdata,   // [7:0] char_out
  output logic                           m_tlast    // last
);
  import itar_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t                state;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [VALUE_W-1:0]    mag;
  logic                  neg;
  logic                  hex;
  logic [IDX_W-1:0]      idx;

  cell_ctl_t             ctl;
  logic [BITS_PER_STEP-1:0] bits_in;
  digit_row_t            digits;
  logic [IDX_W-1:0]      top;
  logic                  in_xact;
  logic                  in_neg;

  assign s_tready = (state == ST_IDLE);
  assign in_xact  = s_tvalid && s_tready;
  assign in_neg   = (s_tuser == KIND_SDEC) && s_tdata[VALUE_W-1];

  assign ctl.clear  = in_xact;
  assign ctl.shift  = (state == ST_CONV);
  assign ctl.dabble = !hex;

  // MSB first into the row
  always_comb begin
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      bits_in[j] = mag[VALUE_W-1-j];
    end
  end

  itar_digit_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .bits_in (bits_in),
    .digits  (digits)
  );

  // most significant nonzero digit; zero if the value is zero
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (digits[i] != '0) begin
        top = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step_cnt <= '0;
          if (in_xact) begin
            mag   <= in_neg ? (~s_tdata + VALUE_W'(1)) : s_tdata;
            neg   <= in_neg;
            hex   <= (s_tuser == KIND_HEX);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag      <= mag << BITS_PER_STEP;
          step_cnt <= step_cnt + STEP_CNT_W'(1);
          if (step_cnt == STEP_CNT_W'(STEPS - 1)) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          m_tvalid <= 1'b1;
          state    <= ST_EMIT;
          if (neg) begin
            m_tdata <= CHAR_MINUS;
            m_tlast <= 1'b0;
            idx     <= top;
          end else begin
            m_tdata <= digit_to_char(digits[top]);
            m_tlast <= (top == '0);
            idx     <= top - IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (m_tlast) begin
              m_tvalid <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              m_tdata <= digit_to_char(digits[idx]);
              m_tlast <= (idx == '0);
              idx     <= idx - IDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/int_to_ascii_radix_checker.sv -----
// ----------------------------------------------------------------------------
// int_to_ascii_radix_checker
// Port-level assertions for the integer-to-ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [itar_pkg::VALUE_W-1:0] s_tdata,
  input logic [itar_pkg::KIND_W-1:0]  s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [itar_pkg::CHAR_W-1:0]  m_tdata,
  input logic                         m_tlast
);
  import itar_pkg::*;

  // one number in flight: input closes once a transaction is taken
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a number is in progress");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input open while characters pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed under stall");

  a_end_of_number: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("character after the last one of a number");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == CHAR_MINUS) ||
                 (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE) ||
                 (m_tdata >= CHAR_LA && m_tdata <= CHAR_LF))
    else $error("character outside the digit set");

  logic unused_in;
  assign unused_in = ^{s_tdata, s_tuser};

endmodule

bind int_to_ascii_radix int_to_ascii_radix_checker u_checker (.*);

// ----- tb/int_to_ascii_radix_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_ascii_radix_tb
// Self-checking bench for the integer-to-ASCII converter. A queue of numbers
// (directed corner values, then random values biased toward digit-count
// boundaries) feeds a stream driver. Each accepted number is turned into its
// expected character string by a local formatter, and a monitor checks every
// output transaction against it. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_tb;
  import itar_pkg::*;

  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;  // no meaning, acts as unsigned
  localparam int NUM_RANDOM = 400;
  localparam int QUIET_LO = 2000;   // cycle window with no idling on either side
  localparam int QUIET_HI = 4500;
  localparam int TAIL_CYCLES = 30;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [KIND_W-1:0]  kind;
    bit                 drain;  // hold off until all text has come back
  } number_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;  // [31:0] value
  logic [KIND_W-1:0]  s_tuser = '0;  // [1:0] kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [CHAR_W-1:0] m_tdata;        // [7:0] char_out
  logic m_tlast;

  number_t    number_q[$];
  text_char_t text_q[$];
  int unsigned n_bad = 0;
  int unsigned cyc_n = 0;
  bit quiet = 1'b0;
  bit drained = 1'b1;

  int_to_ascii_radix dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // state read by both clocked processes is updated away from the rising edge
  always @(negedge clk) begin
    cyc_n   <= cyc_n + 1;
    quiet   <= (cyc_n >= QUIET_LO) && (cyc_n < QUIET_HI);
    drained <= (text_q.size() == 0);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_bad++;
  endtask

  // Formats one number and queues its characters, most significant first.
  task automatic format_number(input logic [VALUE_W-1:0] value,
                               input logic [KIND_W-1:0] kind);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] radix;
    logic [VALUE_W-1:0] rem;
    logic [CHAR_W-1:0]  digits[$];
    text_char_t         tc;
    mag   = value;
    radix = 10;
    if (kind == KIND_SDEC && value[VALUE_W-1]) begin
      tc.ch   = CHAR_MINUS;
      tc.last = 1'b0;
      text_q.push_back(tc);
      mag = ~value + 1'b1;
    end else if (kind == KIND_HEX) begin
      radix = 16;
    end
    do begin
      rem = mag % radix;
      if (rem < 10) digits.push_front(CHAR_ZERO + CHAR_W'(rem));
      else digits.push_front(CHAR_LA + CHAR_W'(rem - 10));
      mag = mag / radix;
    end while (mag != 0);
    foreach (digits[i]) begin
      tc.ch   = digits[i];
      tc.last = (i == digits.size() - 1);
      text_q.push_back(tc);
    end
  endtask

  // input stream driver
  always @(posedge clk) begin : drv_p
    bit fire;
    bit idle;
    number_t nx;
    fire = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (fire) format_number(s_tdata, s_tuser);
      if (!s_tvalid || fire) begin
        idle = !quiet && ($urandom_range(99) < 22);
        if (number_q.size() != 0 && !idle &&
            !(number_q[0].drain && (fire || !drained))) begin
          nx = number_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nx.value;
          s_tuser  <= nx.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output stream monitor
  always @(posedge clk) begin : mon_p
    text_char_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b", m_tdata, m_tlast));
      end else begin
        e = text_q.pop_front();
        if (m_tdata !== e.ch)
          report_mismatch($sformatf("char 0x%02h, want 0x%02h", m_tdata, e.ch));
        if (m_tlast !== e.last)
          report_mismatch($sformatf("last %0b, want %0b (char 0x%02h)",
                                    m_tlast, e.last, e.ch));
      end
    end
    m_tready <= quiet || ($urandom_range(99) >= 22);
  end

  initial begin : stim_p
    number_t nm;
    logic [VALUE_W-1:0] p10;
    logic [VALUE_W-1:0] corner[4];
    logic [KIND_W-1:0] kinds[4];
    corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    kinds  = '{KIND_SDEC, KIND_UDEC, KIND_HEX, KIND_RSVD};

    // directed: field extremes for every kind, then digit rollovers
    nm.drain = 1'b0;
    foreach (kinds[k]) begin
      foreach (corner[c]) begin
        nm.value = corner[c];
        nm.kind  = kinds[k];
        number_q.push_back(nm);
      end
    end
    nm.kind = KIND_SDEC;
    nm.value = 32'd9;          number_q.push_back(nm);
    nm.value = 32'd10;         number_q.push_back(nm);
    nm.value = 32'hFFFF_FFF6;  number_q.push_back(nm);  // -10
    nm.kind = KIND_HEX;
    nm.value = 32'h0000_000F;  number_q.push_back(nm);
    nm.value = 32'h0000_0010;  number_q.push_back(nm);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      nm.drain = (i == 0) || (i == 150) || (i == 320);
      case ($urandom_range(9))
        0: nm.kind = KIND_RSVD;
        1, 2, 3: nm.kind = KIND_SDEC;
        4, 5, 6: nm.kind = KIND_UDEC;
        default: nm.kind = KIND_HEX;
      endcase
      case ($urandom_range(5))
        0, 1: nm.value = $urandom;
        2: nm.value = $urandom_range(999);
        3: begin
          // just below or at a power of ten, sometimes negated
          p10 = 1;
          repeat ($urandom_range(1, 9)) p10 = p10 * 10;
          nm.value = p10 - $urandom_range(1);
          if ($urandom_range(1)) nm.value = ~nm.value + 1'b1;
        end
        4: nm.value = (32'h1 << (4 * $urandom_range(1, 7))) - $urandom_range(1);
        default: nm.value = ~VALUE_W'($urandom_range(999));  // small negative
      endcase
      number_q.push_back(nm);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (number_q.size() != 0 || s_tvalid || text_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (n_bad == 0) begin
      $display("int_to_ascii_radix_tb OK");
    end else begin
      $display("int_to_ascii_radix_tb NOT OK");
    end
    $finish;
  end

  initial begin : limit_p
    #6_000_000;
    $display("int_to_ascii_radix_tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/itar_pkg.sv
rtl/core/itar_cell.sv
rtl/core/itar_digit_chain.sv
rtl/core/int_to_ascii_radix.sv
rtl/core/int_to_ascii_radix_checker.sv
tb/int_to_ascii_radix_tb.sv
